/* rtl/jpdt_pkg.sv */
// jpdt_pkg: shared codes, per-joint state record and helpers of the joint pd torque controller
// no dependencies; imported by the controller unit and the testbench
package jpdt_pkg;

	// request actions
	localparam logic [2:0] ACT_TICK  = 3'd0;
	localparam logic [2:0] ACT_CMD   = 3'd1;
	localparam logic [2:0] ACT_GOAL  = 3'd2;
	localparam logic [2:0] ACT_LIMIT = 3'd3;
	localparam logic [2:0] ACT_START = 3'd4;
	localparam logic [2:0] ACT_LOAD  = 3'd5;

	// result kinds and command run status codes
	localparam logic       KIND_TORQUE = 1'b0;
	localparam logic       KIND_STATUS = 1'b1;
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_COUNT    = 2'd1;
	localparam logic [1:0] ST_LIMIT    = 2'd2;

	// configuration register indexes
	localparam int         CFG_IDX_W = 1;
	localparam int         CFG_DAT_W = 31;
	localparam logic [CFG_IDX_W-1:0] REG_DTM  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FILT = 1'b1;

	// arithmetic constants
	localparam int          PROD_W     = 66;
	localparam int          DIV_W      = 53;
	localparam logic [5:0]  DIV_STEPS  = 6'd53;
	localparam logic signed [32:0] RATE_SCALE = 33'sd1000000;
	localparam logic [16:0] ONE_Q16    = 17'd65536;
	localparam logic [30:0] DTM_RESET  = 31'd65536;
	localparam logic [16:0] FILT_RESET = 17'd328;
	localparam logic signed [31:0] INT_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] INT_MIN = 32'sh80000000;

	typedef struct packed {
		logic signed [31:0] target;
		logic signed [31:0] previous;
		logic signed [31:0] last_err;
		logic signed [31:0] last_rate;
		logic signed [31:0] kp;
		logic signed [31:0] kd;
		logic signed [31:0] kp_goal;
		logic signed [31:0] kd_goal;
		logic signed [31:0] lower;
		logic signed [31:0] upper;
	} joint_state_t;

	localparam joint_state_t JS_RESET = '{
		target: 32'sd0, previous: 32'sd0, last_err: 32'sd0, last_rate: 32'sd0,
		kp: 32'sd0, kd: 32'sd0, kp_goal: 32'sd0, kd_goal: 32'sd0,
		lower: INT_MIN, upper: INT_MAX};

	typedef enum logic [4:0] {
		S_IDLE, S_CMD, S_SET, S_TICK, S_DIVLD, S_DIV, S_DIVFIN, S_MULP, S_MULD,
		S_SUM, S_RL, S_GP, S_GD1, S_GD2, S_SW_RD, S_SW_WR, S_EMIT
	} seq_state_t;

	// clamp a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
		logic signed [31:0] r;
		if (v > PROD_W'(INT_MAX))
			r = INT_MAX;
		else if (v < PROD_W'(INT_MIN))
			r = INT_MIN;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

/* rtl/jpdt_if.sv */
// jpdt_if: valid/ready channels of the joint pd torque controller
// item, result and configuration write channels; no package dependency
interface jpdt_item_if;
	logic               valid;
	logic               ready;
	logic [2:0]         action;
	logic [2:0]         joint;
	logic signed [31:0] measured_position;
	logic signed [31:0] prior_torque;
	logic [15:0]        period_us;
	logic signed [31:0] target_position;
	logic               position_run;
	logic               last_of_command;
	logic signed [31:0] value_low;
	logic signed [31:0] value_high;
	modport source (output valid, action, joint, measured_position, prior_torque, period_us,
		target_position, position_run, last_of_command, value_low, value_high, input ready);
	modport sink (input valid, action, joint, measured_position, prior_torque, period_us,
		target_position, position_run, last_of_command, value_low, value_high, output ready);
endinterface

interface jpdt_result_if;
	logic               valid;
	logic               ready;
	logic               result_kind;
	logic [2:0]         out_joint;
	logic signed [31:0] torque;
	logic signed [31:0] position_error;
	logic signed [31:0] error_rate;
	logic [1:0]         command_status;
	modport source (output valid, result_kind, out_joint, torque, position_error, error_rate,
		command_status, input ready);
	modport sink (input valid, result_kind, out_joint, torque, position_error, error_rate,
		command_status, output ready);
endinterface

interface jpdt_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [30:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/joint_pd_torque_controller_unit.sv */
// joint_pd_torque_controller_unit: per-joint pd torque controller with torque rate limit
// depends on jpdt_pkg and the channel interfaces in jpdt_if.sv
//
//  channel    | dir | payload
//  item_ch    | in  | action, joint, positions, prior torque, period, gains or limits
//  result_ch  | out | kind, joint, torque, error, rate, command status
//  cfg_ch     | in  | register index, write data (always ready)
//
// one item at a time: the sequencer takes a new item only when idle
// a tick with a nonzero period runs the 53-bit bit-serial rate divider, one without skips it;
// the shared 33x33 multiplier runs seven products
// the last element of a position run adds a sweep over all joints
// per-joint state sits in one synchronous memory, staged angles in a second;
// after reset every joint reads its reset values until first written
// the output register is loaded only when empty or taken; a stalled result holds the sequencer
module joint_pd_torque_controller_unit #(
	parameter int JOINTS = 7
) (
	input logic clk,
	input logic arst_n,
	jpdt_item_if.sink item_ch,
	jpdt_result_if.source result_ch,
	jpdt_cfg_if.sink cfg_ch
);
	import jpdt_pkg::*;

	localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
	localparam int CW = $clog2(JOINTS + 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(JOINTS);
	localparam logic [JW-1:0] IDX_LAST = JW'(JOINTS - 1);

	seq_state_t state_q, state_d;

	// item fields held for the sequencer
	logic [2:0]         act_q;
	logic [JW-1:0]      jnt_q;
	logic signed [31:0] meas_q, prior_q, tpos_q, vlo_q, vhi_q;
	logic [15:0]        period_q;
	logic               pmode_q, last_q;

	// configuration and run control
	logic [30:0]   dtm_q;
	logic [16:0]   filt_q;
	logic [CW-1:0] cnt_q;
	logic          viol_q;
	logic [JW-1:0] idx_q;
	logic [1:0]    status_q;

	// memories and read ports
	joint_state_t       st_mem [JOINTS];
	logic signed [31:0] stg_mem [JOINTS];
	logic [JOINTS-1:0]  vld_q;
	joint_state_t       rd_q;
	logic               rd_vld_q;
	logic signed [31:0] stg_rd_q;
	logic               rd_en, wr_en, stg_wr;
	logic [JW-1:0]      rd_addr, wr_addr;
	joint_state_t       wr_data, js;

	// arithmetic
	logic signed [32:0]        mul_a, mul_b;
	logic signed [PROD_W-1:0]  prod_q, g_q, acc_q, abs_c, sum_c;
	logic signed [31:0]        err_q, rate_q, calc_q, tq_q, kp_new_q, err_c, kd_new_c, tq_c;
	logic signed [32:0]        d_c;
	logic signed [33:0]        diff_c, lim_c;
	logic [DIV_W-1:0]          div_n_q;
	logic [15:0]               rem_q;
	logic [16:0]               tr_c;
	logic                      ge_c, neg_q;
	logic [5:0]                dcnt_q;
	logic [16:0]               f_c, nf_c;

	// output register
	logic               res_valid_q, res_kind_q;
	logic [2:0]         res_joint_q;
	logic signed [31:0] res_tq_q, res_err_q, res_rate_q;
	logic [1:0]         res_status_q;

	logic item_acc, joint_ok, out_free;

	assign item_ch.ready = (state_q == S_IDLE);
	assign item_acc      = item_ch.valid & item_ch.ready;
	assign joint_ok      = int'(item_ch.joint) < JOINTS;
	assign cfg_ch.ready  = 1'b1;
	assign out_free      = !res_valid_q || result_ch.ready;

	assign result_ch.valid          = res_valid_q;
	assign result_ch.result_kind    = res_kind_q;
	assign result_ch.out_joint      = res_joint_q;
	assign result_ch.torque         = res_tq_q;
	assign result_ch.position_error = res_err_q;
	assign result_ch.error_rate     = res_rate_q;
	assign result_ch.command_status = res_status_q;

	// entry never written reads as its reset value
	assign js = rd_vld_q ? rd_q : JS_RESET;

	// tick arithmetic
	assign f_c    = (filt_q > ONE_Q16) ? ONE_Q16 : filt_q;
	assign nf_c   = ONE_Q16 - f_c;
	assign err_c  = sat32(PROD_W'(js.target) - PROD_W'(meas_q));
	assign d_c    = 33'(err_c) - 33'(js.last_err);
	assign abs_c  = prod_q[PROD_W-1] ? -prod_q : prod_q;
	assign tr_c   = {rem_q, div_n_q[DIV_W-1]};
	assign ge_c   = tr_c >= {1'b0, period_q};
	assign sum_c  = g_q + prod_q;
	assign kd_new_c = sat32(sum_c >>> 16);
	assign lim_c  = 34'({1'b0, dtm_q});
	assign diff_c = (34'(calc_q) - 34'(prior_q) > lim_c) ? lim_c :
		((34'(calc_q) - 34'(prior_q) < -lim_c) ? -lim_c : 34'(calc_q) - 34'(prior_q));
	assign tq_c   = sat32(PROD_W'(34'(prior_q) + diff_c));

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// next state, memory port control and multiplier operands
	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = idx_q;
		wr_en   = 1'b0;
		wr_addr = jnt_q;
		wr_data = js;
		stg_wr  = 1'b0;
		mul_a   = '0;
		mul_b   = '0;
		case (state_q)
			S_IDLE: begin
				if (item_acc) begin
					if (item_ch.action == ACT_CMD) begin
						rd_en   = 1'b1;
						rd_addr = (cnt_q < CNT_FULL) ? JW'(cnt_q) : '0;
						stg_wr  = cnt_q < CNT_FULL;
						state_d = S_CMD;
					end else if (item_ch.action <= ACT_LOAD && joint_ok) begin
						rd_en   = 1'b1;
						rd_addr = JW'(item_ch.joint);
						state_d = (item_ch.action == ACT_TICK) ? S_TICK : S_SET;
					end
				end
			end
			S_CMD: begin
				if (!last_q || !pmode_q)
					state_d = S_IDLE;
				else
					state_d = S_SW_RD;
			end
			S_SW_RD: begin
				rd_en   = 1'b1;
				state_d = S_SW_WR;
			end
			S_SW_WR: begin
				wr_en   = 1'b1;
				wr_addr = idx_q;
				if (status_q == ST_OK) begin
					wr_data.target = stg_rd_q;
				end else begin
					wr_data.target    = js.previous;
					wr_data.last_err  = '0;
					wr_data.last_rate = '0;
				end
				state_d = (idx_q == IDX_LAST) ? S_EMIT : S_SW_RD;
			end
			S_SET: begin
				wr_en = 1'b1;
				case (act_q)
					ACT_GOAL: begin
						wr_data.kp_goal = vlo_q;
						wr_data.kd_goal = vhi_q;
					end
					ACT_LIMIT: begin
						wr_data.lower = vlo_q;
						wr_data.upper = vhi_q;
					end
					ACT_START: begin
						wr_data.target    = meas_q;
						wr_data.previous  = meas_q;
						wr_data.last_err  = '0;
						wr_data.last_rate = '0;
					end
					default: begin
						wr_data.kp      = vlo_q;
						wr_data.kp_goal = vlo_q;
						wr_data.kd      = vhi_q;
						wr_data.kd_goal = vhi_q;
					end
				endcase
				state_d = S_IDLE;
			end
			S_TICK: begin
				mul_a   = d_c;
				mul_b   = RATE_SCALE;
				state_d = (period_q != '0) ? S_DIVLD : S_MULP;
			end
			S_DIVLD:  state_d = S_DIV;
			S_DIV:    state_d = (dcnt_q == 6'd1) ? S_DIVFIN : S_DIV;
			S_DIVFIN: state_d = S_MULP;
			S_MULP: begin
				mul_a   = 33'(js.kp);
				mul_b   = 33'(err_q);
				state_d = S_MULD;
			end
			S_MULD: begin
				mul_a   = 33'(js.kd);
				mul_b   = 33'(rate_q);
				state_d = S_SUM;
			end
			S_SUM: begin
				mul_a   = 33'($signed({1'b0, f_c}));
				mul_b   = 33'(js.kp_goal);
				state_d = S_RL;
			end
			S_RL: begin
				mul_a   = 33'($signed({1'b0, nf_c}));
				mul_b   = 33'(js.kp);
				state_d = S_GP;
			end
			S_GP: begin
				mul_a   = 33'($signed({1'b0, f_c}));
				mul_b   = 33'(js.kd_goal);
				state_d = S_GD1;
			end
			S_GD1: begin
				mul_a   = 33'($signed({1'b0, nf_c}));
				mul_b   = 33'(js.kd);
				state_d = S_GD2;
			end
			S_GD2: begin
				wr_en             = 1'b1;
				wr_data.previous  = meas_q;
				wr_data.last_err  = err_q;
				wr_data.last_rate = rate_q;
				wr_data.kp        = kp_new_q;
				wr_data.kd        = kd_new_c;
				state_d           = S_EMIT;
			end
			S_EMIT: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state memory, staged angle memory, registered reads
	always_ff @(posedge clk) begin
		if (wr_en)
			st_mem[wr_addr] <= wr_data;
		if (stg_wr)
			stg_mem[JW'(cnt_q)] <= item_ch.target_position;
		if (rd_en) begin
			rd_q     <= st_mem[rd_addr];
			stg_rd_q <= stg_mem[rd_addr];
		end
	end

	// entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en)
				vld_q[wr_addr] <= 1'b1;
			if (rd_en)
				rd_vld_q <= vld_q[rd_addr];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dtm_q  <= DTM_RESET;
			filt_q <= FILT_RESET;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				REG_DTM:  dtm_q  <= cfg_ch.data;
				REG_FILT: filt_q <= cfg_ch.data[16:0];
				default: ;
			endcase
		end
	end

	// run control: element count, limit violation, sweep index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			viol_q   <= 1'b0;
			idx_q    <= '0;
			status_q <= ST_OK;
		end else begin
			case (state_q)
				S_CMD: begin
					if (!last_q) begin
						if (cnt_q < CNT_FULL) begin
							cnt_q <= cnt_q + 1'b1;
							if (tpos_q > js.upper || tpos_q < js.lower)
								viol_q <= 1'b1;
						end
					end else begin
						cnt_q  <= '0;
						viol_q <= 1'b0;
						idx_q  <= '0;
						if (cnt_q + 1'b1 != CNT_FULL)
							status_q <= ST_COUNT;
						else if (viol_q || tpos_q > js.upper || tpos_q < js.lower)
							status_q <= ST_LIMIT;
						else
							status_q <= ST_OK;
					end
				end
				S_SW_WR: idx_q <= idx_q + 1'b1;
				default: ;
			endcase
		end
	end

	// item capture and tick datapath
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a * mul_b);
		if (item_acc) begin
			act_q    <= item_ch.action;
			jnt_q    <= JW'(item_ch.joint);
			meas_q   <= item_ch.measured_position;
			prior_q  <= item_ch.prior_torque;
			period_q <= item_ch.period_us;
			tpos_q   <= item_ch.target_position;
			pmode_q  <= item_ch.position_run;
			last_q   <= item_ch.last_of_command;
			vlo_q    <= item_ch.value_low;
			vhi_q    <= item_ch.value_high;
		end
		case (state_q)
			S_TICK: begin
				err_q  <= err_c;
				rate_q <= js.last_rate;
			end
			S_DIVLD: begin
				neg_q   <= prod_q[PROD_W-1];
				div_n_q <= abs_c[DIV_W-1:0];
				rem_q   <= '0;
				dcnt_q  <= DIV_STEPS;
			end
			S_DIV: begin
				rem_q   <= ge_c ? 16'(tr_c - {1'b0, period_q}) : tr_c[15:0];
				div_n_q <= {div_n_q[DIV_W-2:0], ge_c};
				dcnt_q  <= dcnt_q - 1'b1;
			end
			S_DIVFIN: begin
				if (neg_q)
					rate_q <= (div_n_q > DIV_W'(33'd2147483648)) ? INT_MIN :
						32'(~div_n_q + 1'b1);
				else
					rate_q <= (div_n_q > DIV_W'(INT_MAX)) ? INT_MAX : div_n_q[31:0];
			end
			S_MULD: acc_q <= prod_q >>> 16;
			S_SUM:  calc_q <= sat32(acc_q + (prod_q >>> 16));
			S_RL: begin
				g_q  <= prod_q;
				tq_q <= tq_c;
			end
			S_GP:  kp_new_q <= sat32(sum_c >>> 16);
			S_GD1: g_q <= prod_q;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && out_free) begin
			res_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			if (act_q == ACT_CMD) begin
				res_kind_q   <= KIND_STATUS;
				res_joint_q  <= '0;
				res_tq_q     <= '0;
				res_err_q    <= '0;
				res_rate_q   <= '0;
				res_status_q <= status_q;
			end else begin
				res_kind_q   <= KIND_TORQUE;
				res_joint_q  <= 3'(jnt_q);
				res_tq_q     <= tq_q;
				res_err_q    <= err_q;
				res_rate_q   <= rate_q;
				res_status_q <= ST_OK;
			end
		end
	end

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL)
		else $error("element count beyond joint count");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !result_ch.ready) |=> $stable(res_tq_q) && $stable(res_status_q))
		else $error("waiting result overwritten");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_kind_q == KIND_STATUS) |-> (res_tq_q == '0 && res_err_q == '0))
		else $error("status result carries torque data");

	a_sweep_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SW_RD || state_q == S_SW_WR) |-> int'(idx_q) < JOINTS)
		else $error("sweep index out of range");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIVLD) |=> state_q == S_DIV && dcnt_q == DIV_STEPS)
		else $error("divider not loaded");

endmodule

/* test/jpdt_tb_if.sv */
// jpdt_tb_if: testbench copy of the channel interfaces is not needed; the rtl interfaces are used
// this file holds the stimulus request and expected outcome types for the testbench; depends on jpdt_pkg
`timescale 1ns / 100ps
package jpdt_tb_pkg;
	import jpdt_pkg::*;

	typedef struct {
		logic [2:0]         action;
		logic [2:0]         joint;
		logic signed [31:0] meas;
		logic signed [31:0] prior;
		logic [15:0]        period;
		logic signed [31:0] tpos;
		logic               pmode;
		logic               last;
		logic signed [31:0] vlo;
		logic signed [31:0] vhi;
	} request_t;

	typedef struct {
		logic               kind;
		logic [2:0]         joint;
		logic signed [31:0] torque;
		logic signed [31:0] err;
		logic signed [31:0] rate;
		logic [1:0]         status;
	} outcome_t;
endpackage

/* test/tb_top.sv */
// tb_top: self-checking testbench of joint_pd_torque_controller_unit
// depends on jpdt_pkg, jpdt_if.sv and jpdt_tb_pkg; predicts torque and run status per request
`timescale 1ns / 100ps
module tb_top;
	import jpdt_pkg::*;
	import jpdt_tb_pkg::*;

	localparam int NJ = 7;
	localparam int WATCHDOG = 20000;

	logic clk;
	logic arst_n;

	jpdt_item_if   item_ch();
	jpdt_result_if result_ch();
	jpdt_cfg_if    cfg_ch();

	joint_pd_torque_controller_unit #(.JOINTS(NJ)) DUT (
		.clk(clk), .arst_n(arst_n),
		.item_ch(item_ch.sink), .result_ch(result_ch.source), .cfg_ch(cfg_ch.sink)
	);

	// predicted controller state
	logic signed [31:0] tgt [NJ];
	logic signed [31:0] stg [NJ];
	logic signed [31:0] prev_ang [NJ];
	logic signed [31:0] l_err [NJ];
	logic signed [31:0] l_rate [NJ];
	logic signed [31:0] kp [NJ];
	logic signed [31:0] kd [NJ];
	logic signed [31:0] kp_g [NJ];
	logic signed [31:0] kd_g [NJ];
	logic signed [31:0] lo_lim [NJ];
	logic signed [31:0] hi_lim [NJ];
	int unsigned elem_cnt;
	bit violated;
	logic [30:0] dtm;
	logic [16:0] filt;

	outcome_t expected_q[$];
	int mismatches;
	int idle_cycles;
	bit no_idle;
	bit sink_busy;

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return INT_MAX;
		if (v < -64'sd2147483648) return INT_MIN;
		return v[31:0];
	endfunction

	function automatic longint floor16(longint v);
		return v >>> 16;
	endfunction

	function automatic logic signed [31:0] glide_gain(logic signed [31:0] g,
			logic signed [31:0] goal, longint f);
		longint s;
		s = f * longint'(goal) + (65536 - f) * longint'(g);
		return clamp32(floor16(s));
	endfunction

	task automatic reset_model();
		for (int i = 0; i < NJ; i++) begin
			tgt[i] = 0; stg[i] = 0; prev_ang[i] = 0; l_err[i] = 0; l_rate[i] = 0;
			kp[i] = 0; kd[i] = 0; kp_g[i] = 0; kd_g[i] = 0;
			lo_lim[i] = INT_MIN; hi_lim[i] = INT_MAX;
		end
		elem_cnt = 0;
		violated = 0;
		dtm = DTM_RESET;
		filt = FILT_RESET;
	endtask

	task automatic reject_run();
		for (int i = 0; i < NJ; i++) begin
			tgt[i] = prev_ang[i];
			l_err[i] = 0;
			l_rate[i] = 0;
		end
	endtask

	// work out the result, if any, of one request and advance the state
	task automatic predict_controller(request_t r);
		outcome_t o;
		int unsigned total;
		longint d, raw, diff, lim, f;
		logic signed [31:0] e, rt, calc;
		int j;
		o = '{default: 0};
		j = int'(r.joint);
		if (r.action == ACT_CMD) begin
			if (elem_cnt < NJ) begin
				stg[elem_cnt] = r.tpos;
				if (r.tpos > hi_lim[elem_cnt] || r.tpos < lo_lim[elem_cnt])
					violated = 1;
			end
			total = elem_cnt + 1;
			if (elem_cnt < NJ)
				elem_cnt++;
			if (!r.last)
				return;
			elem_cnt = 0;
			if (!r.pmode) begin
				violated = 0;
				return;
			end
			o.kind = KIND_STATUS;
			if (total != NJ) begin
				o.status = ST_COUNT;
				reject_run();
			end else if (violated) begin
				o.status = ST_LIMIT;
				reject_run();
			end else begin
				o.status = ST_OK;
				for (int i = 0; i < NJ; i++)
					tgt[i] = stg[i];
			end
			violated = 0;
			expected_q.insert(expected_q.size(), o);
			return;
		end
		if (r.action > ACT_LOAD || j >= NJ)
			return;
		case (r.action)
			ACT_TICK: begin
				e = clamp32(longint'(tgt[j]) - longint'(r.meas));
				rt = l_rate[j];
				if (r.period != 0) begin
					d = longint'(e) - longint'(l_err[j]);
					rt = clamp32((d * 1000000) / longint'(r.period));
				end
				raw = floor16(longint'(kp[j]) * longint'(e)) +
					floor16(longint'(kd[j]) * longint'(rt));
				calc = clamp32(raw);
				diff = longint'(calc) - longint'(r.prior);
				lim = longint'(dtm);
				if (diff > lim) diff = lim;
				if (diff < -lim) diff = -lim;
				o.kind = KIND_TORQUE;
				o.joint = 3'(j);
				o.torque = clamp32(longint'(r.prior) + diff);
				o.err = e;
				o.rate = rt;
				l_err[j] = e;
				l_rate[j] = rt;
				prev_ang[j] = r.meas;
				f = (filt > 65536) ? 65536 : longint'(filt);
				kp[j] = glide_gain(kp[j], kp_g[j], f);
				kd[j] = glide_gain(kd[j], kd_g[j], f);
				expected_q.insert(expected_q.size(), o);
			end
			ACT_GOAL: begin
				kp_g[j] = r.vlo; kd_g[j] = r.vhi;
			end
			ACT_LIMIT: begin
				lo_lim[j] = r.vlo; hi_lim[j] = r.vhi;
			end
			ACT_START: begin
				prev_ang[j] = r.meas; tgt[j] = r.meas; l_err[j] = 0; l_rate[j] = 0;
			end
			default: begin
				kp[j] = r.vlo; kp_g[j] = r.vlo; kd[j] = r.vhi; kd_g[j] = r.vhi;
			end
		endcase
	endtask

	// clock
	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// watchdog on cycles without any accepted request or result
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("Verification failed");
			$finish;
		end
	end

	// result sink with random stalls
	initial begin
		result_ch.ready = 0;
		forever begin
			@(negedge clk);
			result_ch.ready <= no_idle || ($urandom_range(99) >= 11);
		end
	end

	// compare every result with the oldest prediction
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result kind=%0d", result_ch.result_kind);
			end else begin
				want = expected_q.pop_front();
				if (result_ch.result_kind !== want.kind || result_ch.out_joint !== want.joint ||
						result_ch.torque !== want.torque ||
						result_ch.position_error !== want.err ||
						result_ch.error_rate !== want.rate ||
						result_ch.command_status !== want.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp k%0d j%0d t%0d e%0d r%0d s%0d got k%0d j%0d t%0d e%0d r%0d s%0d",
							want.kind, want.joint, want.torque, want.err, want.rate,
							want.status, result_ch.result_kind, result_ch.out_joint,
							result_ch.torque, result_ch.position_error,
							result_ch.error_rate, result_ch.command_status);
				end
			end
		end
	end

	// send one request, predicting at acceptance; valid stays up until the next change
	task automatic send_request(request_t r);
		while (!no_idle && $urandom_range(99) < 11) begin
			item_ch.valid <= 0;
			@(negedge clk);
		end
		item_ch.valid <= 1;
		item_ch.action <= r.action;
		item_ch.joint <= r.joint;
		item_ch.measured_position <= r.meas;
		item_ch.prior_torque <= r.prior;
		item_ch.period_us <= r.period;
		item_ch.target_position <= r.tpos;
		item_ch.position_run <= r.pmode;
		item_ch.last_of_command <= r.last;
		item_ch.value_low <= r.vlo;
		item_ch.value_high <= r.vhi;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		predict_controller(r);
		@(negedge clk);
	endtask

	// wait until every prediction has arrived plus the longest tick latency
	task automatic drain();
		item_ch.valid <= 0;
		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic write_register(logic [0:0] idx, logic [30:0] value);
		cfg_ch.valid <= 1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		if (idx == REG_DTM)
			dtm = value;
		else
			filt = value[16:0];
		@(negedge clk);
		cfg_ch.valid <= 0;
		@(negedge clk);
	endtask

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(5))
			0: return INT_MAX;
			1: return INT_MIN;
			2: return $signed($urandom_range(131072)) - 65536;
			default: return $urandom;
		endcase
	endfunction

	function automatic request_t random_request(logic [2:0] act);
		request_t r;
		r.action = act;
		r.joint = ($urandom_range(19) == 0) ? 3'd7 : 3'($urandom_range(NJ - 1));
		r.meas = rand_word();
		r.prior = rand_word();
		r.period = ($urandom_range(4) == 0) ? 16'd0 : 16'($urandom);
		r.tpos = rand_word();
		r.pmode = ($urandom_range(7) != 0);
		r.last = 0;
		r.vlo = rand_word();
		r.vhi = rand_word();
		return r;
	endfunction

	// one command run with a given element count
	task automatic send_run(int count, bit pmode);
		request_t r;
		for (int i = 0; i < count; i++) begin
			r = random_request(ACT_CMD);
			if ($urandom_range(3) != 0)
				r.tpos = $signed($urandom_range(131072)) - 65536;
			r.last = (i == count - 1);
			r.pmode = pmode;
			send_request(r);
		end
	endtask

	task automatic test_directed();
		request_t r;
		r = random_request(ACT_LOAD); r.joint = 0; r.vlo = 32'sh10000; r.vhi = 32'sh800;
		send_request(r);
		r = random_request(ACT_GOAL); r.joint = 0; r.vlo = INT_MAX; r.vhi = INT_MIN;
		send_request(r);
		r = random_request(ACT_START); r.joint = 0; r.meas = INT_MIN;
		send_request(r);
		r = random_request(ACT_TICK); r.joint = 0; r.meas = INT_MAX; r.period = 16'hffff;
		send_request(r);
		r = random_request(ACT_TICK); r.joint = 0; r.period = 0;
		send_request(r);
		r = random_request(ACT_TICK); r.joint = 6; r.period = 1; r.meas = INT_MIN;
		send_request(r);
		r = random_request(ACT_TICK); r.joint = 7;
		send_request(r);
		r = random_request(3'd6); send_request(r);
		r = random_request(3'd7); send_request(r);
		r = random_request(ACT_LIMIT); r.joint = 2; r.vlo = -100; r.vhi = 100;
		send_request(r);
		send_run(NJ, 1);
		send_run(3, 1);
		send_run(9, 1);
		send_run(NJ, 0);
		r = random_request(ACT_LIMIT); r.joint = 2; r.vlo = INT_MIN; r.vhi = INT_MAX;
		send_request(r);
		drain();
	endtask

	task automatic test_random(int n);
		request_t r;
		int sent;
		int pick;
		sent = 0;
		while (sent < n) begin
			pick = $urandom_range(99);
			if (pick < 12) begin
				send_run(($urandom_range(4) == 0) ? $urandom_range(1, 10) : NJ,
					$urandom_range(9) != 0);
				sent += NJ;
			end else begin
				if (pick < 60) r = random_request(ACT_TICK);
				else if (pick < 70) r = random_request(ACT_GOAL);
				else if (pick < 78) r = random_request(ACT_LIMIT);
				else if (pick < 88) r = random_request(ACT_START);
				else if (pick < 97) r = random_request(ACT_LOAD);
				else r = random_request(3'($urandom_range(6, 7)));
				if (r.action == ACT_LIMIT && $urandom_range(1)) begin
					r.vlo = -$signed($urandom_range(70000));
					r.vhi = $urandom_range(70000);
				end
				send_request(r);
				sent++;
			end
		end
		drain();
	endtask

	task automatic test_settings();
		write_register(REG_DTM, 31'h7fffffff);
		write_register(REG_FILT, 31'd65536);
		test_random(200);
		write_register(REG_DTM, 31'd0);
		write_register(REG_FILT, 31'd0);
		test_random(150);
		write_register(REG_DTM, 31'($urandom_range(1, 1 << 20)));
		write_register(REG_FILT, 31'h1ffff);
		test_random(150);
		no_idle = 1;
		write_register(REG_FILT, 31'($urandom_range(65536)));
		test_random(250);
		no_idle = 0;
		write_register(REG_DTM, 31'($urandom));
		test_random(400);
	endtask

	initial begin
		mismatches = 0;
		idle_cycles = 0;
		no_idle = 0;
		item_ch.valid = 0;
		item_ch.action = 0; item_ch.joint = 0; item_ch.measured_position = 0;
		item_ch.prior_torque = 0; item_ch.period_us = 0; item_ch.target_position = 0;
		item_ch.position_run = 0; item_ch.last_of_command = 0;
		item_ch.value_low = 0; item_ch.value_high = 0;
		cfg_ch.valid = 0; cfg_ch.index = 0; cfg_ch.data = 0;
		reset_model();
		arst_n = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		test_directed();
		test_settings();
		if (mismatches == 0 && expected_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

/* files.f */
rtl/jpdt_pkg.sv
rtl/jpdt_if.sv
rtl/joint_pd_torque_controller_unit.sv
test/jpdt_tb_if.sv
test/tb_top.sv
